// ===== hdl/lpht_pkg.sv =====
// lpht_pkg: sizes, codes, slot entry layout and interface structs shared by
// the linear probe hash table core and its remainder unit.
// No dependencies.
`default_nettype none

package lpht_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int SIZE_W      = IDX_W + 1;
   localparam int KEY_W       = 32;
   localparam int VALUE_W     = 32;
   localparam int STEP_W      = $clog2(KEY_W);

   // operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_UPDATE = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_QUERY  = 2'd3;

   // result status codes
   localparam logic [1:0] RES_OK        = 2'd0;
   localparam logic [1:0] RES_DUPLICATE = 2'd1;
   localparam logic [1:0] RES_NOT_FOUND = 2'd2;
   localparam logic [1:0] RES_FULL      = 2'd3;

   // slot status codes
   localparam logic [1:0] SLOT_EMPTY = 2'd0;
   localparam logic [1:0] SLOT_USED  = 2'd1;
   localparam logic [1:0] SLOT_DEAD  = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_TABLE_SIZE = 2'd0;
   localparam logic [1:0] CSR_OVERWRITE  = 2'd1;

   // one stored slot
   typedef struct packed {
      logic [1:0]         status;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // remainder unit request and response
   typedef struct packed {
      logic              start;
      logic [KEY_W-1:0]  key;
      logic [SIZE_W-1:0] size;
   } mod_req_type;

   typedef struct packed {
      logic             done;
      logic [IDX_W-1:0] home;
   } mod_rsp_type;

endpackage

`default_nettype wire

// ===== hdl/linear_probe_hash_table_core.sv =====
// linear_probe_hash_table_core: top level, operation sequencer, slot store
// and configuration registers of the linear probe hash table.
// Depends on lpht_pkg, lpht_mod and lpht_ram.
//
// Usage:
//  - req channel carries one operation per transaction: req_tuser holds the
//    opcode (insert, update, delete, query), req_tdata the key and value.
//  - rsp channel returns exactly one transaction per request with the status
//    in rsp_tuser and the found value and slot index in rsp_tdata.
//  - csr channel writes table_size (index 0) and insert_overwrites (index 1);
//    it is always ready and must only be used while the core is idle.
//  - sequence: an accept state, the home slot remainder (one bit a cycle of
//    the 32 bit key), then per slot probed a registered RAM read and a check
//    with write back, then the move into the output register. The worst case
//    walks every slot in use.
//  - one operation at a time: req_tready is high only while idle. The next
//    request can be taken while a result still waits in the output register.
//  - when rsp_tready is low the result is held; a later finished operation
//    waits in its final state until the output register frees.
//  - reset clears the slot valid bits, so every slot reads as empty at once;
//    table_size returns to 256 and insert_overwrites to 0.
`default_nettype none

module linear_probe_hash_table_core
   import lpht_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request: tuser = opcode[1:0]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,
   // request: tdata = lookup_key[31:0], entry_value[63:32]
   input  wire logic [63:0] req_tdata,
   // response: tuser = status[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [1:0]       rsp_tuser,
   // response: tdata = found_value[31:0], slot_index[39:32]
   output logic [39:0]      rsp_tdata,
   // configuration write
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [8:0]  csr_data
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_HASH  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_CHECK = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [SIZE_W-1:0]  table_size_ff, table_size_in;
   logic               overwrite_ff, overwrite_in;

   logic [1:0]         op_ff, op_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [IDX_W-1:0]   loc_ff, loc_in;
   logic [SIZE_W-1:0]  cnt_ff, cnt_in;

   logic [1:0]         res_status_ff, res_status_in;
   logic [VALUE_W-1:0] res_found_ff, res_found_in;
   logic [IDX_W-1:0]   res_slot_ff, res_slot_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0] rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]   rsp_slot_ff, rsp_slot_in;

   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;

   logic [SIZE_W-1:0]  live_n;
   logic [SIZE_W-1:0]  loc_plus;
   logic [SIZE_W-1:0]  cnt_plus;
   logic [1:0]         slot_st;
   logic               key_eq;
   logic               over;
   logic               is_insert;

   mod_req_type        mod_req;
   mod_rsp_type        mod_rsp;

   logic               ram_we;
   entry_type          ram_wdata;
   logic               ram_re;
   logic [ENTRY_W-1:0] ram_rdata;
   entry_type          rd_entry;

   // home slot unit
   lpht_mod u_mod (
      .clock (clock),
      .reset (reset),
      .req   (mod_req),
      .rsp   (mod_rsp)
   );

   // slot store: status, key and value in one word
   lpht_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (loc_ff),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (loc_ff),
      .rd_data (ram_rdata)
   );

   assign rd_entry = entry_type'(ram_rdata);

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      table_size_in = table_size_ff;
      overwrite_in  = overwrite_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TABLE_SIZE: table_size_in = csr_data;
            CSR_OVERWRITE:  overwrite_in  = csr_data[0];
            default:        ;
         endcase
      end
   end

   // slots in use, zero taken as one and clipped to the depth
   always_comb begin
      if (table_size_ff == '0) begin
         live_n = SIZE_W'(1);
      end else if (table_size_ff > SIZE_W'(TABLE_DEPTH)) begin
         live_n = SIZE_W'(TABLE_DEPTH);
      end else begin
         live_n = table_size_ff;
      end
   end

   // probe decode
   assign loc_plus  = {1'b0, loc_ff} + SIZE_W'(1);
   assign cnt_plus  = cnt_ff + SIZE_W'(1);
   assign slot_st   = valid_ff[loc_ff] ? rd_entry.status : SLOT_EMPTY;
   assign key_eq    = (rd_entry.key == key_ff);
   assign is_insert = (op_ff == OP_INSERT) || (op_ff == OP_UPDATE);
   assign over      = (op_ff == OP_UPDATE) || overwrite_ff;

   assign req_tready = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      loc_in        = loc_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_slot_in   = rsp_slot_ff;
      valid_in      = valid_ff;
      mod_req.start = 1'b0;
      mod_req.key   = req_tdata[KEY_W-1:0];
      mod_req.size  = live_n;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_wdata     = '{status: SLOT_USED, key: key_ff, value: val_ff};

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in         = req_tuser;
               key_in        = req_tdata[KEY_W-1:0];
               val_in        = req_tdata[63:32];
               mod_req.start = 1'b1;
               state_in      = ST_HASH;
            end
         end
         ST_HASH: begin
            if (mod_rsp.done) begin
               loc_in   = mod_rsp.home;
               cnt_in   = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            ram_re   = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            res_found_in = '0;
            res_slot_in  = '0;
            state_in     = ST_DONE;
            if (is_insert && (slot_st != SLOT_USED)) begin
               // claim an empty or deleted slot
               ram_we           = 1'b1;
               valid_in[loc_ff] = 1'b1;
               res_status_in    = RES_OK;
               res_slot_in      = loc_ff;
            end else if (is_insert && key_eq) begin
               if (over) begin
                  ram_we        = 1'b1;
                  ram_wdata     = '{status: SLOT_USED, key: rd_entry.key, value: val_ff};
                  res_status_in = RES_OK;
                  res_slot_in   = loc_ff;
               end else begin
                  res_status_in = RES_DUPLICATE;
               end
            end else if (!is_insert && (slot_st == SLOT_EMPTY)) begin
               res_status_in = RES_NOT_FOUND;
            end else if (!is_insert && (slot_st == SLOT_USED) && key_eq) begin
               res_status_in = RES_OK;
               res_slot_in   = loc_ff;
               if (op_ff == OP_DELETE) begin
                  ram_we    = 1'b1;
                  ram_wdata = '{status: SLOT_DEAD, key: rd_entry.key,
                                value: rd_entry.value};
               end else begin
                  res_found_in = rd_entry.value;
               end
            end else if (cnt_plus == live_n) begin
               // every slot in use visited
               res_status_in = is_insert ? RES_FULL : RES_NOT_FOUND;
            end else begin
               cnt_in   = cnt_plus;
               loc_in   = (loc_plus >= live_n) ? '0 : loc_plus[IDX_W-1:0];
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
               rsp_slot_in   = res_slot_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         valid_ff      <= '0;
         table_size_ff <= SIZE_W'(TABLE_DEPTH);
         overwrite_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         valid_ff      <= valid_in;
         table_size_ff <= table_size_in;
         overwrite_ff  <= overwrite_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      loc_ff        <= loc_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_slot_ff, rsp_found_ff};

   // remainder unit only finishes while the sequencer waits for it
   a_mod_done_in_hash: assert property (@(posedge clock) disable iff (reset)
      mod_rsp.done |-> (state_ff == ST_HASH))
      else $error("home slot result outside hash state");

   // the store is only written from the check state
   a_write_in_check: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_CHECK))
      else $error("slot store written outside check state");

   // probing never runs past the slots in use
   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> ((cnt_ff < live_n) && ({1'b0, loc_ff} < live_n)))
      else $error("probe beyond table size");

   // error results carry slot zero and no value
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != RES_OK))
         |-> ((rsp_slot_ff == '0) && (rsp_found_ff == '0)))
      else $error("error result with nonzero slot or value");

   // a check state always follows a read
   a_read_then_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_CHECK))
      else $error("read not followed by check");

endmodule

`default_nettype wire

// ===== hdl/lpht_ram.sv =====
// lpht_ram: generic simple dual port RAM, one write and one registered read.
// No dependencies.
`default_nettype none

module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/lpht_mod.sv =====
// lpht_mod: home slot unit, a restoring remainder of the key magnitude by the
// table size, one quotient bit a cycle, with the sign fix-up on the way out.
// Depends on lpht_pkg.
`default_nettype none

module lpht_mod
   import lpht_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mod_req_type req,
   output mod_rsp_type      rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [KEY_W-1:0]  dvd_ff, dvd_in;
   logic [IDX_W-1:0]  rem_ff, rem_in;
   logic              neg_ff, neg_in;
   logic [SIZE_W-1:0] size_ff, size_in;

   logic [KEY_W-1:0]  mag;
   logic [SIZE_W-1:0] trial;
   logic [SIZE_W-1:0] fixed;

   // magnitude of the signed key
   assign mag = req.key[KEY_W-1] ? (~req.key + KEY_W'(1)) : req.key;
   // shift in the next dividend bit
   assign trial = {rem_ff, dvd_ff[KEY_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      size_in = size_ff;
      if (req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = mag;
         rem_in  = '0;
         neg_in  = req.key[KEY_W-1];
         size_in = req.size;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[KEY_W-2:0], 1'b0};
         if (trial >= size_ff) begin
            rem_in = IDX_W'(trial - size_ff);
         end else begin
            rem_in = trial[IDX_W-1:0];
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(KEY_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
      size_ff <= size_in;
   end

   // negative keys map to size minus remainder, unless it divides evenly
   assign fixed = size_ff - {1'b0, rem_ff};
   assign rsp.done = done_ff;
   assign rsp.home = (neg_ff && (rem_ff != '0)) ? fixed[IDX_W-1:0] : rem_ff;

endmodule

`default_nettype wire

// ===== dv/linear_probe_hash_table_core_test.sv =====
// linear_probe_hash_table_core_test: self-checking bench for the linear probe hash table core,
// with a scoreboard that mirrors the slot store and predicts every response transaction.
// Depends on lpht_pkg and linear_probe_hash_table_core.
`timescale 1ns / 100ps

module linear_probe_hash_table_core_test;
   import lpht_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 3_000_000;
   localparam int          ITEMS_PER_PHASE = 82;
   localparam int          NUM_PHASES = 10;

   // one response transaction as the core returns it
   typedef struct packed {
      logic [1:0]         status;
      logic [VALUE_W-1:0] found_value;
      logic [7:0]         slot_index;
   } table_result_type;

   // shadow of the slot store and registers, plus the results still owed
   class lpht_scoreboard;
      logic [1:0]         slot_state [TABLE_DEPTH];
      logic [KEY_W-1:0]   slot_key   [TABLE_DEPTH];
      logic [VALUE_W-1:0] slot_value [TABLE_DEPTH];
      logic [SIZE_W-1:0]  size_reg;
      logic               overwrite_reg;
      table_result_type   owed_q [$];
      int                 errors;

      function new();
         foreach (slot_state[i]) begin
            slot_state[i] = SLOT_EMPTY;
            slot_key[i]   = '0;
            slot_value[i] = '0;
         end
         size_reg      = SIZE_W'(TABLE_DEPTH);
         overwrite_reg = 1'b0;
         errors        = 0;
      endfunction

      function void write_reg(logic [1:0] index, logic [8:0] data);
         if (index == CSR_TABLE_SIZE) size_reg = data;
         else if (index == CSR_OVERWRITE) overwrite_reg = data[0];
      endfunction

      // zero acts as one, anything past the store saturates
      function int slots_in_use();
         if (size_reg == 0) return 1;
         if (size_reg > TABLE_DEPTH) return TABLE_DEPTH;
         return int'(size_reg);
      endfunction

      // signed key reduced to a nonnegative remainder
      function int home_of(logic [KEY_W-1:0] key, int n);
         longint k;
         longint r;
         k = longint'($signed(key));
         r = k % n;
         if (r < 0) r += n;
         return int'(r);
      endfunction

      function int outstanding();
         return owed_q.size();
      endfunction

      // accepted request transaction: apply it to the shadow store
      function void note(logic [1:0] op, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
         table_result_type res;
         int               n;
         int               loc;
         bit               over;
         res = '0;
         n   = slots_in_use();
         loc = home_of(key, n);
         if (op == OP_INSERT || op == OP_UPDATE) begin
            over = (op == OP_UPDATE) || overwrite_reg;
            res.status = RES_FULL;
            for (int c = 0; c < n; c++) begin
               if (slot_state[loc] == SLOT_USED) begin
                  if (slot_key[loc] == key) begin
                     if (over) begin
                        slot_value[loc] = value;
                        res.status      = RES_OK;
                        res.slot_index  = 8'(loc);
                     end else begin
                        res.status = RES_DUPLICATE;
                     end
                     break;
                  end
               end else begin
                  // empty or tombstone: claim it
                  slot_state[loc] = SLOT_USED;
                  slot_key[loc]   = key;
                  slot_value[loc] = value;
                  res.status      = RES_OK;
                  res.slot_index  = 8'(loc);
                  break;
               end
               loc = (loc + 1 >= n) ? 0 : loc + 1;
            end
         end else begin
            // lookup stops on empty, passes over tombstones
            res.status = RES_NOT_FOUND;
            for (int c = 0; c < n; c++) begin
               if (slot_state[loc] == SLOT_EMPTY) break;
               if (slot_state[loc] == SLOT_USED && slot_key[loc] == key) begin
                  res.status     = RES_OK;
                  res.slot_index = 8'(loc);
                  if (op == OP_DELETE) slot_state[loc] = SLOT_DEAD;
                  else res.found_value = slot_value[loc];
                  break;
               end
               loc = (loc + 1 >= n) ? 0 : loc + 1;
            end
         end
         owed_q.push_back(res);
      endfunction

      // response transaction against the oldest expectation
      function void check(table_result_type got);
         table_result_type want;
         if (owed_q.size() == 0) begin
            $display("%0t: unexpected result status=%0d value=%h slot=%0d",
                     $time, got.status, got.found_value, got.slot_index);
            errors++;
            return;
         end
         want = owed_q.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
         end
         if (got.found_value !== want.found_value) begin
            $display("%0t: found_value expected %h actual %h",
                     $time, want.found_value, got.found_value);
            errors++;
         end
         if (got.slot_index !== want.slot_index) begin
            $display("%0t: slot_index expected %0d actual %0d",
                     $time, want.slot_index, got.slot_index);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [1:0]  req_tuser = OP_QUERY;
   logic [63:0] req_tdata = '0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [1:0]  rsp_tuser;
   wire  [39:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   wire         csr_ready;
   logic [1:0]  csr_index = CSR_TABLE_SIZE;
   logic [8:0]  csr_data = '0;

   lpht_scoreboard     sb;
   bit                 calm = 1'b0;
   logic [KEY_W-1:0]   recent_keys [$];

   linear_probe_hash_table_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // clock
   initial begin
      forever #4 clock = ~clock;
   end

   // mostly short idle stretches, now and then a long one
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // keys: reuse of live keys, collisions around the modulus, extremes, noise
   function automatic logic [KEY_W-1:0] pick_key(int n);
      int r;
      r = $urandom_range(0, 99);
      if (recent_keys.size() != 0 && r < 45)
         return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      if (r < 65) return KEY_W'($urandom_range(0, 2 * n + 3));
      if (r < 75) return -KEY_W'($urandom_range(1, 2 * n + 3));
      if (r < 85) return KEY_W'(n * $urandom_range(0, 40) + $urandom_range(0, 1));
      if (r < 90) begin
         case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            default: return 32'h0000_0000;
         endcase
      end
      return $urandom();
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [1:0] pick_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return OP_INSERT;
      if (r < 50) return OP_UPDATE;
      if (r < 70) return OP_DELETE;
      return OP_QUERY;
   endfunction

   // one request transaction; valid stays high when the next follows at once
   task automatic send_item(logic [1:0] op, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {value, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note(op, key, value);
      if (op == OP_INSERT || op == OP_UPDATE) begin
         recent_keys.push_back(key);
         if (recent_keys.size() > 64) void'(recent_keys.pop_front());
      end
   endtask

   // wait until every owed result is back and the core has settled
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] index, logic [8:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(index, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // response side: random back-pressure and checking
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check('{status: rsp_tuser, found_value: rsp_tdata[31:0],
                       slot_index: rsp_tdata[39:32]});
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            stall_left = pick_gap();
            if (stall_left > 0) begin
               rsp_tready <= 1'b0;
               stall_left--;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // watchdog
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("status: fail");
      $finish;
   end

   // stimulus
   initial begin : stimulus
      int phase_size [NUM_PHASES];
      int n;
      logic [1:0] op;
      phase_size = '{8, 1, 256, 3, 0, 16, 511, 5, 64, 2};
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty table, key extremes, wrap at the top, duplicates and tombstones
      send_item(OP_QUERY,  32'd5, 32'h0);
      send_item(OP_DELETE, 32'd5, 32'h0);
      send_item(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
      send_item(OP_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
      send_item(OP_INSERT, 32'h8000_0000, 32'h1234_5678);
      send_item(OP_INSERT, 32'hffff_ffff, 32'ha5a5_a5a5);
      send_item(OP_INSERT, 32'h0000_0000, 32'h5555_5555);
      send_item(OP_UPDATE, 32'h0000_0000, 32'hdead_beef);
      send_item(OP_QUERY,  32'h0000_0000, 32'h0);
      send_item(OP_DELETE, 32'h8000_0000, 32'h0);
      send_item(OP_QUERY,  32'hffff_ffff, 32'h0);
      send_item(OP_INSERT, 32'd256, 32'h0bad_cafe);
      send_item(OP_UPDATE, 32'd512, 32'h0102_0304);

      // two slots, overwrite mode: full table, overwrite, tombstone reuse
      drain();
      write_csr(CSR_TABLE_SIZE, 9'd2);
      write_csr(CSR_OVERWRITE, 9'd1);
      send_item(OP_INSERT, 32'd4, 32'h0000_0044);
      send_item(OP_UPDATE, 32'd4, 32'h0000_0045);
      send_item(OP_INSERT, 32'h0000_0000, 32'h1111_1111);
      send_item(OP_DELETE, 32'd256, 32'h0);
      send_item(OP_QUERY,  32'd4, 32'h0);
      send_item(OP_INSERT, -32'sd3, 32'h3333_3333);

      // size zero acts as one slot
      drain();
      write_csr(CSR_TABLE_SIZE, 9'd0);
      write_csr(CSR_OVERWRITE, 9'd0);
      send_item(OP_QUERY,  32'h0000_0000, 32'h0);
      send_item(OP_INSERT, 32'd7, 32'h7777_7777);

      // oversize saturates, entries past the old size come back into reach
      drain();
      write_csr(CSR_TABLE_SIZE, 9'd511);
      send_item(OP_QUERY, 32'h7fff_ffff, 32'h0);
      send_item(OP_QUERY, 32'd512, 32'h0);

      // random phases over a range of sizes, store kept between phases
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         write_csr(CSR_TABLE_SIZE, 9'(phase_size[p]));
         write_csr(CSR_OVERWRITE, 9'(p % 2));
         calm = (p == 2) || ($urandom_range(0, 4) == 0);
         n = sb.slots_in_use();
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            op = pick_op();
            send_item(op, pick_key(n), pick_value());
         end
      end

      calm = 1'b0;
      drain();
      repeat (600) @(posedge clock);
      if (sb.outstanding() != 0)
         $display("%0t: %0d expected results never arrived", $time, sb.outstanding());
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/lpht_pkg.sv
hdl/lpht_ram.sv
hdl/lpht_mod.sv
hdl/linear_probe_hash_table_core.sv
dv/linear_probe_hash_table_core_test.sv
